### hdl/e2q_pkg.sv
// package: shared constants, types and tables for euler to quaternion core
package e2q_pkg;

  localparam int CORDIC_STEPS = 16;
  localparam int ANG_W = 16;
  localparam int Z_W = 34;
  localparam int XY_W = 34;
  localparam int TRIG_W = 18;
  localparam int OUT_W = 16;

  localparam logic signed [Z_W-1:0] Q30_PI = 34'sd3373259426;
  localparam logic signed [Z_W-1:0] Q30_HALF_PI = 34'sd1686629713;
  localparam logic signed [XY_W-1:0] Q30_GAIN = 34'sd652032874;
  localparam logic signed [63:0] OUT_MAX = 64'sd16384;

  // one cordic lane for one angle
  typedef struct packed {
    logic signed [XY_W-1:0] x;
    logic signed [XY_W-1:0] y;
    logic signed [Z_W-1:0] z;
    logic flip;
  } lane_t;

  // arctangent table in q30
  function automatic logic signed [Z_W-1:0] atan_q30(input int i);
    logic signed [Z_W-1:0] r;
    r = '0;
    case (i)
      0: r = 34'sd843314857;
      1: r = 34'sd497837829;
      2: r = 34'sd263043836;
      3: r = 34'sd133525158;
      4: r = 34'sd67021686;
      5: r = 34'sd33543515;
      6: r = 34'sd16775850;
      7: r = 34'sd8388437;
      8: r = 34'sd4194282;
      9: r = 34'sd2097149;
      10: r = 34'sd1048575;
      11: r = 34'sd524287;
      12: r = 34'sd262143;
      13: r = 34'sd131071;
      14: r = 34'sd65535;
      15: r = 34'sd32767;
      16: r = 34'sd16383;
      17: r = 34'sd8191;
      18: r = 34'sd4095;
      19: r = 34'sd2047;
      20: r = 34'sd1023;
      21: r = 34'sd511;
      22: r = 34'sd255;
      23: r = 34'sd127;
      24: r = 34'sd63;
      25: r = 34'sd31;
      26: r = 34'sd15;
      27: r = 34'sd7;
      28: r = 34'sd3;
      29: r = 34'sd1;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

### hdl/e2q_cell.sv
// module: one cordic micro-rotation cell for three angles, registered
module e2q_cell (
  input  logic                 clk,
  input  logic                 en,
  input  logic [5:0]           step,
  input  e2q_pkg::lane_t [2:0] lane_in,
  output e2q_pkg::lane_t [2:0] lane_out
);

  e2q_pkg::lane_t [2:0] lane_next;

  // rotate each lane toward zero residual angle
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      lane_next[k] = lane_in[k];
      if (!lane_in[k].z[e2q_pkg::Z_W-1]) begin
        lane_next[k].x = lane_in[k].x - (lane_in[k].y >>> step);
        lane_next[k].y = lane_in[k].y + (lane_in[k].x >>> step);
        lane_next[k].z = lane_in[k].z - e2q_pkg::atan_q30(int'(step));
      end else begin
        lane_next[k].x = lane_in[k].x + (lane_in[k].y >>> step);
        lane_next[k].y = lane_in[k].y - (lane_in[k].x >>> step);
        lane_next[k].z = lane_in[k].z + e2q_pkg::atan_q30(int'(step));
      end
    end
  end

  // stage register, held while the pipeline is stalled
  always_ff @(posedge clk) begin
    if (en) lane_out <= lane_next;
  end

endmodule

### hdl/euler_to_quaternion_core.sv
// module: euler roll pitch yaw to quaternion, pipelined cordic cell chain
//
// channel | dir | content
// s_axis  | in  | roll, pitch, yaw angles
// m_axis  | out | quaternion w, x, y, z
//
// the result passes through the fold register, one register per cordic cell,
// the rounding register, two multiply stages and the output register; one
// transfer per cycle sustained while the output is not stalled.
// the whole pipeline advances only when the output register can take data.
// reset clears the valid bits only.
module euler_to_quaternion_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [47:0] s_axis_tdata,  // roll_angle, pitch_angle, yaw_angle
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [63:0] m_axis_tdata   // quat_w, quat_x, quat_y, quat_z
);

  localparam int N = e2q_pkg::CORDIC_STEPS;
  localparam int DEPTH = N + 5;

  logic adv;
  logic [DEPTH-1:0] vld;
  e2q_pkg::lane_t [2:0] chain [N+1];
  e2q_pkg::lane_t [2:0] fold;
  e2q_pkg::lane_t [2:0] lane0;

  assign adv = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = adv;

  // valid shift line
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[DEPTH-2:0], s_axis_tvalid};
    end
  end
  assign m_axis_tvalid = vld[DEPTH-1];

  // quadrant folding of half angles
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      logic signed [e2q_pkg::Z_W-1:0] z;
      z = e2q_pkg::Z_W'($signed(s_axis_tdata[e2q_pkg::ANG_W*k +: e2q_pkg::ANG_W])) <<< 16;
      fold[k].x = e2q_pkg::Q30_GAIN;
      fold[k].y = '0;
      fold[k].flip = 1'b0;
      if (z > e2q_pkg::Q30_HALF_PI) begin
        z = z - e2q_pkg::Q30_PI;
        fold[k].flip = 1'b1;
      end else if (z < -e2q_pkg::Q30_HALF_PI) begin
        z = z + e2q_pkg::Q30_PI;
        fold[k].flip = 1'b1;
      end
      fold[k].z = z;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) lane0 <= fold;
  end
  assign chain[0] = lane0;

  // cordic cell chain; every cell register shares the pipeline enable
  for (genvar i = 0; i < N; i++) begin : g_cell
    e2q_cell u_cell (
      .clk      (clk),
      .en       (adv),
      .step     (6'(i)),
      .lane_in  (chain[i]),
      .lane_out (chain[i+1])
    );
  end

  // round to q15 with flip
  logic signed [e2q_pkg::TRIG_W-1:0] cs [3];
  logic signed [e2q_pkg::TRIG_W-1:0] sn [3];
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < 3; k++) begin
        logic signed [e2q_pkg::XY_W-1:0] xx, yy;
        xx = chain[N][k].flip ? -chain[N][k].x : chain[N][k].x;
        yy = chain[N][k].flip ? -chain[N][k].y : chain[N][k].y;
        cs[k] <= e2q_pkg::TRIG_W'((xx + 34'sd16384) >>> 15);
        sn[k] <= e2q_pkg::TRIG_W'((yy + 34'sd16384) >>> 15);
      end
    end
  end

  // first products: roll by pitch terms, carry yaw
  logic signed [35:0] p_cc, p_ss, p_sc, p_cs;
  logic signed [e2q_pkg::TRIG_W-1:0] cy1, sy1;
  always_ff @(posedge clk) begin
    if (adv) begin
      p_cc <= cs[0] * cs[1];
      p_ss <= sn[0] * sn[1];
      p_sc <= sn[0] * cs[1];
      p_cs <= cs[0] * sn[1];
      cy1 <= cs[2];
      sy1 <= sn[2];
    end
  end

  // second products and sums, operands sign-extended to the sum width
  logic signed [63:0] sw, sx, sy, sz;
  always_ff @(posedge clk) begin
    if (adv) begin
      sw <= p_cc * cy1 + p_ss * sy1;
      sx <= p_sc * cy1 - p_cs * sy1;
      sy <= p_cs * cy1 + p_sc * sy1;
      sz <= p_cc * sy1 - p_ss * cy1;
    end
  end

  function automatic logic [e2q_pkg::OUT_W-1:0] finish(input logic signed [63:0] v);
    logic signed [63:0] r;
    r = (v + 64'sd1073741824) >>> 31;
    if (r > e2q_pkg::OUT_MAX) r = e2q_pkg::OUT_MAX;
    if (r < -e2q_pkg::OUT_MAX) r = -e2q_pkg::OUT_MAX;
    return r[e2q_pkg::OUT_W-1:0];
  endfunction

  // output register
  always_ff @(posedge clk) begin
    if (adv) m_axis_tdata <= {finish(sz), finish(sy), finish(sx), finish(sw)};
  end

endmodule
